[rtl/ple_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine: field widths,
// action and status codes, and the controller/datapath interface structs.
// ---------------------------------------------------------------------------
package ple_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int ACT_W  = 4;
    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;

    localparam logic [ACT_W-1:0] ACT_INS_FRONT = 4'd0;
    localparam logic [ACT_W-1:0] ACT_INS_BACK  = 4'd1;
    localparam logic [ACT_W-1:0] ACT_INS_AT    = 4'd2;
    localparam logic [ACT_W-1:0] ACT_DEL_FRONT = 4'd3;
    localparam logic [ACT_W-1:0] ACT_DEL_BACK  = 4'd4;
    localparam logic [ACT_W-1:0] ACT_DEL_AT    = 4'd5;
    localparam logic [ACT_W-1:0] ACT_COUNT     = 4'd6;
    localparam logic [ACT_W-1:0] ACT_SHOW      = 4'd7;
    localparam logic [ACT_W-1:0] ACT_SHOW_REV  = 4'd8;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

    // what a request turns into once decoded
    typedef enum logic [1:0] {
        KIND_SIMPLE,
        KIND_INS,
        KIND_DEL,
        KIND_SHOW
    } kind_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } ple_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  rem_zero;
    } ple_stat_t;

endpackage
`default_nettype wire

[rtl/positional_list_engine.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed 32-bit values with positional insert and
// delete, count, and forward or reverse display.
// ---------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Results come out
// one per cycle, each for a single cycle under result_valid. They cannot be
// stalled, so the receiver must take every one. Count, rejected requests
// (full, empty, bad position) and unused action codes finish at once. Their
// result shows the next cycle, and busy is never raised. Insert or delete at
// 1-based position p walks the elements that move, one per cycle, through the
// store's single read port. Front is p = 1. Back is p = count + 1 for insert
// and p = count for delete. The walk is followed by a closing step, and the
// result shows as busy falls. A display emits its results on consecutive
// cycles. The final result, with last set, comes in the last busy cycle. The
// longest transaction is a full display.
module positional_list_engine #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ple_pkg::ACT_W-1:0]         action,
    input  logic signed [ple_pkg::DATA_W-1:0] value,
    input  logic [ple_pkg::POS_W-1:0]         position,
    output logic                              result_valid,
    output logic [ple_pkg::STAT_W-1:0]        status,
    output logic signed [ple_pkg::DATA_W-1:0] element,
    output logic [ple_pkg::CNT_W-1:0]         length,
    output logic                              last
);
    import ple_pkg::*;

    ple_cmd_t  cmd;
    ple_stat_t stat;

    ple_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .stat (stat),
        .cmd  (cmd)
    );

    ple_dpath #(
        .CAPACITY(CAPACITY)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .action      (action),
        .value       (value),
        .position    (position),
        .result_valid(result_valid),
        .status      (status),
        .element     (element),
        .length      (length),
        .last        (last)
    );

endmodule
`default_nettype wire

[rtl/ple_ram.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// ple_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ---------------------------------------------------------------------------
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[rtl/ple_ctrl.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// ple_ctrl
// Sequencer for the positional list engine: accepts a transaction and, unless
// it finishes at once, runs the element walk, then the closing step.
// ---------------------------------------------------------------------------
module ple_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ple_pkg::ple_stat_t stat,
    output ple_pkg::ple_cmd_t  cmd
);
    import ple_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (stat.kind != KIND_SIMPLE)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.rem_zero)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule
`default_nettype wire

[rtl/ple_dpath.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// ple_dpath
// Datapath of the positional list engine: request decode, element count,
// walk pointer, element store and the result register.
// ---------------------------------------------------------------------------
module ple_dpath #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ple_pkg::ple_cmd_t                   cmd,
    output ple_pkg::ple_stat_t                  stat,
    input  logic [ple_pkg::ACT_W-1:0]           action,
    input  logic signed [ple_pkg::DATA_W-1:0]   value,
    input  logic [ple_pkg::POS_W-1:0]           position,
    output logic                                result_valid,
    output logic [ple_pkg::STAT_W-1:0]          status,
    output logic signed [ple_pkg::DATA_W-1:0]   element,
    output logic [ple_pkg::CNT_W-1:0]           length,
    output logic                                last
);
    import ple_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    // decode
    kind_t             dec_kind;
    logic [STAT_W-1:0] dec_status;
    logic [CNT_W-1:0]  dec_idx;
    logic [ADDR_W-1:0] dec_ptr;
    logic [CNT_W-1:0]  dec_rem;
    logic              dec_up;
    logic              ins_bad;
    logic              del_bad;

    // state
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    kind_t             kind_reg, kind_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic              up_reg, up_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic              pend_last_reg, pend_last_next;

    logic              rv_reg, rv_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0] element_reg, element_next;
    logic [CNT_W-1:0]  length_reg, length_next;
    logic              last_reg, last_next;

    // store
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    assign ins_bad = (position == '0) || (position > cnt_reg + CNT_W'(1));
    assign del_bad = (position == '0) || (position > cnt_reg);

    always_comb
    begin
        dec_kind   = KIND_SIMPLE;
        dec_status = ST_OK;
        dec_idx    = '0;
        unique case (action)
            ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT:
            begin
                if (action == ACT_INS_AT && ins_bad)
                begin
                    dec_status = ST_BADPOS;
                end
                else if (cnt_reg >= CAP_C)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    dec_kind = KIND_INS;
                    if (action == ACT_INS_BACK)
                    begin
                        dec_idx = cnt_reg;
                    end
                    else if (action == ACT_INS_AT)
                    begin
                        dec_idx = position - POS_W'(1);
                    end
                end
            end
            ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_AT:
            begin
                if (cnt_reg == '0)
                begin
                    dec_status = ST_EMPTY;
                end
                else if (action == ACT_DEL_AT && del_bad)
                begin
                    dec_status = ST_BADPOS;
                end
                else
                begin
                    dec_kind = KIND_DEL;
                    if (action == ACT_DEL_BACK)
                    begin
                        dec_idx = cnt_reg - CNT_W'(1);
                    end
                    else if (action == ACT_DEL_AT)
                    begin
                        dec_idx = position - POS_W'(1);
                    end
                end
            end
            ACT_SHOW, ACT_SHOW_REV:
            begin
                if (cnt_reg == '0)
                begin
                    dec_status = ST_EMPTY;
                end
                else
                begin
                    dec_kind = KIND_SHOW;
                end
            end
            default:
            begin
                dec_status = ST_OK;
            end
        endcase
    end

    // walk setup: insert moves elements up from the back, delete moves them
    // down from the gap, display reads in the requested order
    always_comb
    begin
        dec_ptr = '0;
        dec_rem = '0;
        dec_up  = 1'b1;
        unique case (dec_kind)
            KIND_INS:
            begin
                dec_ptr = ADDR_W'(cnt_reg - CNT_W'(1));
                dec_rem = cnt_reg - dec_idx;
                dec_up  = 1'b0;
            end
            KIND_DEL:
            begin
                dec_ptr = ADDR_W'(dec_idx + CNT_W'(1));
                dec_rem = cnt_reg - dec_idx - CNT_W'(1);
                dec_up  = 1'b1;
            end
            KIND_SHOW:
            begin
                dec_rem = cnt_reg;
                if (action == ACT_SHOW_REV)
                begin
                    dec_ptr = ADDR_W'(cnt_reg - CNT_W'(1));
                    dec_up  = 1'b0;
                end
            end
            default:
            begin
                dec_rem = '0;
            end
        endcase
    end

    assign stat.kind     = dec_kind;
    assign stat.rem_zero = (rem_reg == '0);

    always_comb
    begin
        cnt_next       = cnt_reg;
        kind_next      = kind_reg;
        ptr_next       = ptr_reg;
        rem_next       = rem_reg;
        up_next        = up_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        pend_last_next = pend_last_reg;
        rv_next        = 1'b0;
        status_next    = status_reg;
        element_next   = element_reg;
        length_next    = length_reg;
        last_next      = last_reg;
        ram_we         = 1'b0;
        ram_waddr      = pend_addr_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = ptr_reg;

        if (cmd.load)
        begin
            kind_next = dec_kind;
            idx_next  = ADDR_W'(dec_idx);
            val_next  = $unsigned(value);
            ptr_next  = dec_ptr;
            rem_next  = dec_rem;
            up_next   = dec_up;
            if (dec_kind == KIND_SIMPLE)
            begin
                rv_next      = 1'b1;
                status_next  = dec_status;
                element_next = '0;
                length_next  = cnt_reg;
                last_next    = 1'b1;
            end
        end

        if (cmd.scan)
        begin
            // read one element; next cycle it is written back or loaded into the result register
            if (rem_reg != '0)
            begin
                ram_re         = 1'b1;
                ptr_next       = up_reg ? ptr_reg + ADDR_W'(1) : ptr_reg - ADDR_W'(1);
                rem_next       = rem_reg - CNT_W'(1);
                pend_next      = 1'b1;
                pend_addr_next = up_reg ? ptr_reg - ADDR_W'(1) : ptr_reg + ADDR_W'(1);
                pend_last_next = (rem_reg == CNT_W'(1));
            end
            if (pend_reg)
            begin
                if (kind_reg == KIND_SHOW)
                begin
                    rv_next      = 1'b1;
                    status_next  = ST_OK;
                    element_next = ram_rdata;
                    length_next  = cnt_reg;
                    last_next    = pend_last_reg;
                end
                else
                begin
                    ram_we = 1'b1;
                end
            end
        end

        if (cmd.finish)
        begin
            if (kind_reg == KIND_INS)
            begin
                ram_we       = 1'b1;
                ram_waddr    = idx_reg;
                ram_wdata    = val_reg;
                cnt_next     = cnt_reg + CNT_W'(1);
                rv_next      = 1'b1;
                status_next  = ST_OK;
                element_next = '0;
                length_next  = cnt_reg + CNT_W'(1);
                last_next    = 1'b1;
            end
            else if (kind_reg == KIND_DEL)
            begin
                cnt_next     = cnt_reg - CNT_W'(1);
                rv_next      = 1'b1;
                status_next  = ST_OK;
                element_next = '0;
                length_next  = cnt_reg - CNT_W'(1);
                last_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            kind_reg <= KIND_SIMPLE;
            rem_reg  <= '0;
            pend_reg <= 1'b0;
            rv_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            kind_reg <= kind_next;
            rem_reg  <= rem_next;
            pend_reg <= pend_next;
            rv_reg   <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        up_reg        <= up_next;
        idx_reg       <= idx_next;
        val_reg       <= val_next;
        pend_addr_reg <= pend_addr_next;
        pend_last_reg <= pend_last_next;
        status_reg    <= status_next;
        element_reg   <= element_next;
        length_reg    <= length_next;
        last_reg      <= last_next;
    end

    ple_ram #(
        .WIDTH(DATA_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign result_valid = rv_reg;
    assign status       = status_reg;
    assign element      = $signed(element_reg);
    assign length       = length_reg;
    assign last         = last_reg;

`ifndef NO_ASSERTIONS
    a_pend_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(cmd.scan))
        else $error("pending element without a preceding walk cycle");

    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (rem_reg == '0) && !pend_reg)
        else $error("closing step with walk still in flight");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CAP_C)
        else $error("element count above capacity");

    a_partial_is_display: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg && !last_reg |-> (status_reg == ST_OK) && (kind_reg == KIND_SHOW))
        else $error("non-final result outside a display transaction");
`endif

endmodule
`default_nettype wire
